// File: rtl/brb_pkg.sv
// ============================================================================
// Byte ring buffer package
// Shared widths, command codes, beat payload types and controller commands.
// ============================================================================
package brb_pkg;

    localparam int DEPTH = 1024;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = AW + 1;

    typedef enum logic [2:0] {
        CMD_PUSH  = 3'd0,
        CMD_POP   = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_PEEK  = 3'd3,
        CMD_ADV_W = 3'd4,
        CMD_ADV_R = 3'd5
    } t_cmd_code;

    typedef struct packed {
        logic [2:0]    cmd;
        logic [7:0]    data_in;
        logic [LW-1:0] offset;
        logic [LW-1:0] count;
    } t_in;

    typedef struct packed {
        logic [7:0]    data_out;
        logic          ok;
        logic [LW-1:0] read_length;
        logic [LW-1:0] write_length;
        logic [LW-1:0] read_segment;
        logic [LW-1:0] write_segment;
    } t_out;

    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_LEN,
        STEP_EXEC,
        STEP_SEG_LEN,
        STEP_SEG_PTR,
        STEP_SEG_OUT
    } t_step;

    typedef struct packed {
        logic  capture;
        t_step step;
    } t_ctl;

endpackage

// File: rtl/byte_ring_buffer_with_full_flag_top.sv
// ============================================================================
// Byte ring buffer with full flag
// Channel  | Signals                              | Beat
// ---------+--------------------------------------+---------------------------
// in       | i_in_valid, o_in_ready, i_in         | brb_pkg::t_in command
// out      | o_out_valid, i_out_ready, o_out      | brb_pkg::t_out result
// cfg      | i_cfg_we, i_cfg_data                 | ring capacity, 11 bits
//
// o_out_valid is registered, rises after the last segment step and holds until
// i_out_ready; o_in_ready is registered and returns only after that handshake,
// so no new beat is taken until the result is accepted. The controller steps lengths, execute with the
// single RAM port, then three segment steps. Reset (synchronous, active low)
// empties the ring and sets capacity to 1024; a capacity write empties it too.
// The store is not cleared.
// ============================================================================
module byte_ring_buffer_with_full_flag_top (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [brb_pkg::LW-1:0] i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  brb_pkg::t_in           i_in,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output brb_pkg::t_out          o_out
);

    brb_pkg::t_ctl ctl;

    brb_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_ctl       (ctl)
    );

    brb_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_ctl      (ctl),
        .o_out      (o_out)
    );

endmodule

// File: rtl/brb_ram.sv
// ============================================================================
// Generic single-port RAM
// One write or read per cycle, registered read data.
// ============================================================================
module brb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/brb_ctl.sv
// ============================================================================
// Byte ring buffer controller
// Sequences one beat through length, execute and segment steps.
// ============================================================================
module brb_ctl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output brb_pkg::t_ctl o_ctl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_EXEC,
        ST_SEG_LEN,
        ST_SEG_PTR,
        ST_SEG_OUT,
        ST_DONE
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= ST_LEN;
                        r_in_ready <= 1'b0;
                    end
                end
                ST_LEN:     r_state <= ST_EXEC;
                ST_EXEC:    r_state <= ST_SEG_LEN;
                ST_SEG_LEN: r_state <= ST_SEG_PTR;
                ST_SEG_PTR: r_state <= ST_SEG_OUT;
                ST_SEG_OUT: begin
                    r_state     <= ST_DONE;
                    r_out_valid <= 1'b1;
                end
                ST_DONE: begin
                    if (i_out_ready) begin
                        r_state     <= ST_IDLE;
                        r_out_valid <= 1'b0;
                        r_in_ready  <= 1'b1;
                    end
                end
                default: begin
                    r_state     <= ST_IDLE;
                    r_in_ready  <= 1'b1;
                    r_out_valid <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_ctl.capture = i_in_valid && r_in_ready;
        case (r_state)
            ST_LEN:     o_ctl.step = brb_pkg::STEP_LEN;
            ST_EXEC:    o_ctl.step = brb_pkg::STEP_EXEC;
            ST_SEG_LEN: o_ctl.step = brb_pkg::STEP_SEG_LEN;
            ST_SEG_PTR: o_ctl.step = brb_pkg::STEP_SEG_PTR;
            ST_SEG_OUT: o_ctl.step = brb_pkg::STEP_SEG_OUT;
            default:    o_ctl.step = brb_pkg::STEP_IDLE;
        endcase
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;

    a_ready_valid_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_in_ready && r_out_valid))
        else $error("input ready while a result is pending");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && r_in_ready) |=> (r_state == ST_LEN))
        else $error("accepted beat did not start the sequence");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEG_OUT) |=> (r_out_valid && !r_in_ready))
        else $error("result not presented after segment step");

endmodule

// File: rtl/brb_dp.sv
// ============================================================================
// Byte ring buffer datapath
// Pointers, full flag, capacity, byte store and result registers.
// ============================================================================
module brb_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [brb_pkg::LW-1:0]     i_cfg_data,
    input  brb_pkg::t_in               i_in,
    input  brb_pkg::t_ctl              i_ctl,
    output brb_pkg::t_out              o_out
);

    localparam int AW = brb_pkg::AW;
    localparam int LW = brb_pkg::LW;

    logic [LW-1:0] r_cap;
    logic [AW-1:0] r_rp;
    logic [AW-1:0] r_wp;
    logic          r_full;
    brb_pkg::t_in  r_in;
    logic [LW-1:0] r_rl;
    logic [LW-1:0] r_wl;
    logic          r_ok;
    logic          r_rd;
    logic [AW-1:0] r_ro;
    logic [AW-1:0] r_wo;
    logic          r_rz;
    logic          r_wz;
    logic [7:0]    r_dout;
    logic [LW-1:0] r_rseg;
    logic [LW-1:0] r_wseg;

    logic [LW-1:0] n_cap;
    logic [LW-1:0] c_rl;
    logic [LW-1:0] adv_r;
    logic [LW-1:0] add_w;
    logic [LW-1:0] add_r;
    logic [AW-1:0] w_wr;
    logic [AW-1:0] c_rwr;
    logic          e_ok;
    logic          e_we;
    logic          e_rd;
    logic [AW-1:0] e_addr;
    logic [AW-1:0] n_rp;
    logic [AW-1:0] n_wp;
    logic          n_full;
    logic [LW-1:0] s_or;
    logic [LW-1:0] s_ow;
    logic [7:0]    ram_rdata;

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] p,
                                             input logic [LW-1:0] n,
                                             input logic [LW-1:0] cap);
        logic [AW+1:0] s;
        logic [AW+1:0] d;
        s = {2'b00, p} + {1'b0, n};
        d = s - {1'b0, cap};
        if (s >= {1'b0, cap}) begin
            return d[AW-1:0];
        end
        return s[AW-1:0];
    endfunction

    always_comb begin
        if (i_cfg_data == '0) begin
            n_cap = LW'(1);
        end else if (i_cfg_data > LW'(brb_pkg::DEPTH)) begin
            n_cap = LW'(brb_pkg::DEPTH);
        end else begin
            n_cap = i_cfg_data;
        end
    end

    always_comb begin
        if (r_wp < r_rp) begin
            c_rl = r_cap - ({1'b0, r_rp} - {1'b0, r_wp});
        end else if (r_full) begin
            c_rl = r_cap;
        end else begin
            c_rl = {1'b0, r_wp} - {1'b0, r_rp};
        end
    end

    always_comb begin
        adv_r = (r_in.count <= r_rl) ? r_in.count : r_rl;
        case (r_in.cmd)
            brb_pkg::CMD_PUSH:  add_w = LW'(1);
            brb_pkg::CMD_WRITE: add_w = r_in.offset;
            default:            add_w = r_in.count;
        endcase
        case (r_in.cmd)
            brb_pkg::CMD_POP:  add_r = LW'(1);
            brb_pkg::CMD_PEEK: add_r = r_in.offset;
            default:           add_r = adv_r;
        endcase
        w_wr  = f_wrap(r_wp, add_w, r_cap);
        c_rwr = f_wrap(r_rp, add_r, r_cap);
    end

    always_comb begin
        e_ok   = 1'b0;
        e_we   = 1'b0;
        e_rd   = 1'b0;
        e_addr = r_wp;
        n_rp   = r_rp;
        n_wp   = r_wp;
        n_full = r_full;
        case (r_in.cmd)
            brb_pkg::CMD_PUSH: begin
                e_ok = (r_wl != '0);
                e_we = e_ok;
                if (e_ok) begin
                    n_wp   = w_wr;
                    n_full = (w_wr == r_rp);
                end
            end
            brb_pkg::CMD_POP: begin
                e_ok   = (r_rl != '0);
                e_rd   = e_ok;
                e_addr = r_rp;
                if (e_ok) begin
                    n_rp   = c_rwr;
                    n_full = 1'b0;
                end
            end
            brb_pkg::CMD_WRITE: begin
                e_ok   = (r_in.offset < r_wl);
                e_we   = e_ok;
                e_addr = w_wr;
            end
            brb_pkg::CMD_PEEK: begin
                e_ok   = (r_in.offset < r_rl);
                e_rd   = e_ok;
                e_addr = c_rwr;
            end
            brb_pkg::CMD_ADV_W: begin
                e_ok = (r_in.count <= r_wl);
                if (e_ok && r_in.count != '0) begin
                    n_wp   = w_wr;
                    n_full = (w_wr == r_rp);
                end
            end
            brb_pkg::CMD_ADV_R: begin
                e_ok = (r_in.count <= r_rl);
                if (adv_r != '0) begin
                    n_rp   = c_rwr;
                    n_full = 1'b0;
                end
            end
            default: begin
                e_ok = 1'b0;
            end
        endcase
    end

    assign s_or = (r_in.offset < r_rl) ? r_in.offset : r_rl;
    assign s_ow = (r_in.offset < r_wl) ? r_in.offset : r_wl;

    brb_ram #(
        .WIDTH (8),
        .DEPTH (brb_pkg::DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    ((i_ctl.step == brb_pkg::STEP_EXEC) && e_we),
        .i_addr  (e_addr),
        .i_wdata (r_in.data_in),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap  <= LW'(brb_pkg::DEPTH);
            r_rp   <= '0;
            r_wp   <= '0;
            r_full <= 1'b0;
        end else if (i_cfg_we) begin
            r_cap  <= n_cap;
            r_rp   <= '0;
            r_wp   <= '0;
            r_full <= 1'b0;
        end else if (i_ctl.step == brb_pkg::STEP_EXEC) begin
            r_rp   <= n_rp;
            r_wp   <= n_wp;
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_in <= i_in;
        end
        case (i_ctl.step)
            brb_pkg::STEP_LEN: begin
                r_rl <= c_rl;
                r_wl <= r_cap - c_rl;
            end
            brb_pkg::STEP_EXEC: begin
                r_ok <= e_ok;
                r_rd <= e_rd;
            end
            brb_pkg::STEP_SEG_LEN: begin
                r_rl   <= c_rl;
                r_wl   <= r_cap - c_rl;
                r_dout <= r_rd ? ram_rdata : 8'd0;
            end
            brb_pkg::STEP_SEG_PTR: begin
                r_ro <= f_wrap(r_rp, s_or, r_cap);
                r_wo <= f_wrap(r_wp, s_ow, r_cap);
                r_rz <= (r_rl == s_or);
                r_wz <= (r_wl == s_ow);
            end
            brb_pkg::STEP_SEG_OUT: begin
                if (r_rz) begin
                    r_rseg <= '0;
                end else if (r_wp > r_ro) begin
                    r_rseg <= {1'b0, r_wp} - {1'b0, r_ro};
                end else begin
                    r_rseg <= r_cap - {1'b0, r_ro};
                end
                if (r_wz) begin
                    r_wseg <= '0;
                end else if (r_rp > r_wo) begin
                    r_wseg <= {1'b0, r_rp} - {1'b0, r_wo};
                end else begin
                    r_wseg <= r_cap - {1'b0, r_wo};
                end
            end
            default: ;
        endcase
    end

    assign o_out.data_out      = r_dout;
    assign o_out.ok            = r_ok;
    assign o_out.read_length   = r_rl;
    assign o_out.write_length  = r_wl;
    assign o_out.read_segment  = r_rseg;
    assign o_out.write_segment = r_wseg;

    a_full_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_rp == r_wp))
        else $error("full flag set with pointers apart");

    a_cap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cap != '0) && (r_cap <= LW'(brb_pkg::DEPTH)))
        else $error("capacity out of range");

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_rp} < r_cap) && ({1'b0, r_wp} < r_cap))
        else $error("pointer beyond ring");

endmodule
